FILE: hw/rtl/erma_pkg.sv
`default_nettype none

package erma_pkg;

	// Width of the internal time base; timestamps are reduced modulo 2^TIME_BITS.
	localparam int TIME_BITS = 48;
	localparam int TS_W      = 48;
	localparam int RATE_W    = 32;
	localparam int SI_W      = 16;
	localparam int AW_W      = 8;

	// Numerator of the rate division: sample_interval * 1e6 * 256 fits in 44 bits.
	localparam int NUM_W = 44;
	localparam logic [NUM_W-1:0] RATE_SCALE = NUM_W'(64'd256000000);
	localparam logic [RATE_W-1:0] RATE_MAX  = '1;

	// The blend avg*(w-1) + rate stays below 2^41.
	localparam int BLEND_W = RATE_W + AW_W + 1;

	// The shared divider produces one quotient bit per cycle.
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [SI_W-1:0] SI_RESET = SI_W'(10);
	localparam logic [AW_W-1:0] AW_RESET = AW_W'(4);

	localparam int PADDR_W = 3;

	typedef enum logic {
		REG_SAMPLE_INTERVAL = 1'b0,
		REG_AVERAGE_WINDOW  = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RATE_GO,
		S_RATE_WAIT,
		S_BLEND,
		S_AVG_GO,
		S_AVG_WAIT,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic            func;
		logic [TS_W-1:0] timestamp_us;
	} evt_item_t;

	typedef struct packed {
		logic [RATE_W-1:0] rate_avg;
		logic              sampled;
	} res_item_t;

	typedef struct packed {
		logic [SI_W-1:0] sample_interval;
		logic [AW_W-1:0] average_window;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/event_rate_meter_averaged_top.sv
// An item that does not complete a sample goes from S_IDLE to S_EMIT and then into the result
// register; a sampling event first runs the rate division, the blend and the average division.
// One item at a time: the input stalls until the item has left S_EMIT, and a sampling event
// holds it through both divisions of the single bit-serial divider, which runs them in turn.
// Reset (arst_n low, asynchronous): count, reference time and average clear to zero,
// sample_interval returns to 10 and average_window to 4; no result is pending.
`default_nettype none

module event_rate_meter_averaged_top import erma_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               evt_valid,
	output logic                    evt_stall,
	input  wire evt_item_t          evt_data,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output res_item_t               res_data
);

	cfg_t        cfg;
	div_status_t div_st;
	logic [NUM_W-1:0]     div_quot;
	logic                 div_start;
	logic [NUM_W-1:0]     div_dividend;
	logic [TIME_BITS-1:0] div_divisor;

	state_t state_q, state_nxt;

	// Architectural state of the meter.
	logic [SI_W-1:0]      event_count_q;
	logic [TIME_BITS-1:0] ref_time_q;
	logic [RATE_W-1:0]    avg_q;

	// Working registers of one sample.
	logic [SI_W-1:0]      n_q;
	logic [AW_W-1:0]      w_q;
	logic [TIME_BITS-1:0] elapsed_q;
	logic [RATE_W-1:0]    rate_q;
	logic [BLEND_W-1:0]   blend_q;
	logic                 sampled_q;

	// Result register, which lets the next request in while this one waits.
	logic                 res_valid_q;
	res_item_t            res_data_q;

	logic                 accept;
	logic                 load_res;
	logic [TIME_BITS-1:0] now;
	logic [SI_W-1:0]      n_eff;
	logic [AW_W-1:0]      w_eff;
	logic                 hit;
	logic [RATE_W-1:0]    rate_sat;

	erma_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	erma_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.status   (div_st)
	);

	// A zero interval or window behaves as one.
	assign now   = TIME_BITS'(evt_data.timestamp_us);
	assign n_eff = (cfg.sample_interval == '0) ? SI_W'(1) : cfg.sample_interval;
	assign w_eff = (cfg.average_window == '0) ? AW_W'(1) : cfg.average_window;

	// The count may sit above a lowered interval; the next event then samples.
	assign hit = ({1'b0, event_count_q} + (SI_W+1)'(1)) >= {1'b0, n_eff};

	// Any quotient bit above the 32-bit range saturates the rate. A zero elapsed
	// time makes the divider return all ones, which saturates the same way.
	assign rate_sat = (div_quot[NUM_W-1:RATE_W] != '0) ? RATE_MAX : div_quot[RATE_W-1:0];

	assign accept = evt_valid && !evt_stall;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = (!evt_data.func && hit) ? S_RATE_GO : S_EMIT;
				end
			end
			S_RATE_GO:   state_nxt = S_RATE_WAIT;
			S_RATE_WAIT: if (div_st.done) state_nxt = S_BLEND;
			S_BLEND:     state_nxt = S_AVG_GO;
			S_AVG_GO:    state_nxt = S_AVG_WAIT;
			S_AVG_WAIT:  if (div_st.done) state_nxt = S_EMIT;
			S_EMIT:      if (!res_valid_q || !res_stall) state_nxt = S_IDLE;
			default:     state_nxt = S_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		evt_stall    = 1'b1;
		div_start    = 1'b0;
		load_res     = 1'b0;
		div_dividend = NUM_W'(n_q) * RATE_SCALE;
		div_divisor  = elapsed_q;
		unique case (state_q)
			S_IDLE:    evt_stall = 1'b0;
			S_RATE_GO: div_start = 1'b1;
			S_AVG_GO: begin
				div_start    = 1'b1;
				div_dividend = NUM_W'(blend_q);
				div_divisor  = TIME_BITS'(w_q);
			end
			S_EMIT:    load_res = !res_valid_q || !res_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			event_count_q <= '0;
			ref_time_q    <= '0;
			avg_q         <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_IDLE && accept) begin
				if (evt_data.func) begin
					ref_time_q <= now;
				end else if (hit) begin
					ref_time_q    <= now;
					event_count_q <= '0;
				end else begin
					event_count_q <= event_count_q + SI_W'(1);
				end
			end
			if (state_q == S_AVG_WAIT && div_st.done) begin
				// The blended quotient never exceeds the larger of avg and rate.
				avg_q <= div_quot[RATE_W-1:0];
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			n_q       <= n_eff;
			w_q       <= w_eff;
			elapsed_q <= now - ref_time_q;
			sampled_q <= !evt_data.func && hit;
		end
		if (state_q == S_RATE_WAIT && div_st.done) begin
			rate_q <= rate_sat;
		end
		if (state_q == S_BLEND) begin
			blend_q <= BLEND_W'(avg_q) * BLEND_W'(w_q - AW_W'(1)) + BLEND_W'(rate_q);
		end
		if (load_res) begin
			res_data_q.rate_avg <= avg_q;
			res_data_q.sampled  <= sampled_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		event_count_q != '1)
		else $error("event count reached an impossible value");
	a_avg_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(avg_q) |-> $past(state_q) == S_AVG_WAIT && $past(div_st.done))
		else $error("average changed outside the average division");
	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RATE_WAIT || state_q == S_AVG_WAIT) |-> div_st.busy || div_st.done)
		else $error("waiting on a divider that is not running");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/erma_apb_regs.sv
`default_nettype none

module erma_apb_regs import erma_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic [SI_W-1:0] sample_interval_q;
	logic [AW_W-1:0] average_window_q;
	logic            wr_en;
	reg_idx_t        idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_interval_q <= SI_RESET;
			average_window_q  <= AW_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_SAMPLE_INTERVAL: sample_interval_q <= pwdata[SI_W-1:0];
				REG_AVERAGE_WINDOW:  average_window_q  <= pwdata[AW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SAMPLE_INTERVAL: prdata = 32'(sample_interval_q);
			REG_AVERAGE_WINDOW:  prdata = 32'(average_window_q);
			default:             prdata = '0;
		endcase
	end

	assign cfg.sample_interval = sample_interval_q;
	assign cfg.average_window  = average_window_q;

endmodule

`default_nettype wire

FILE: hw/rtl/erma_serial_div.sv
`default_nettype none

module erma_serial_div import erma_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [NUM_W-1:0]     dividend,
	input  wire logic [TIME_BITS-1:0] divisor,
	output logic      [NUM_W-1:0]     quotient,
	output div_status_t               status
);

	// Restoring division: the dividend shifts out at the top while quotient
	// bits shift in at the bottom of the same register.
	logic [NUM_W-1:0]     dvd_q;
	logic [TIME_BITS-1:0] dvs_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [TIME_BITS:0]   trial;
	logic                 fits;

	assign trial = {rem_q, dvd_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NUM_W-2:0], fits};
			rem_q <= fits ? TIME_BITS'(trial - {1'b0, dvs_q}) : trial[TIME_BITS-1:0];
		end
	end

	assign quotient    = dvd_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a running division");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");
`endif

endmodule

`default_nettype wire
